// File: rtl/core/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Types, sizes and helpers shared by the subband dedispersion sum unit.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int NCHAN      = 64;
  localparam int NSUB       = 4;
  localparam int NDM        = 8;
  localparam int HIST       = 1024;
  localparam int CH_PER_SUB = (NCHAN + NSUB - 1) / NSUB;

  localparam int CH_W       = 6;
  localparam int DM_W       = 3;
  localparam int DLY_W      = 10;
  localparam int SMP_W      = 16;
  localparam int SUM_W      = 22;
  localparam int BAND_W     = 3;
  localparam int CNT_W      = 4;
  localparam int LAG_W      = 10;
  localparam int ACC_W      = SUM_W + 1;
  localparam int SUB_W      = $clog2(NSUB);
  localparam int POS_W      = $clog2(HIST);
  localparam int HADDR_W    = $clog2(NCHAN * HIST);
  localparam int DADDR_W    = $clog2(NDM * NCHAN);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG      = 2'd1;

  localparam logic [CNT_W-1:0] DM_COUNT_RST = 4'd8;
  localparam logic [LAG_W-1:0] LAG_RST      = 10'd1023;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_SAMPLE,
    JOB_FRAME
  } sds_kind_t;

  typedef struct packed {
    sds_kind_t         kind;
    logic [CH_W-1:0]   chan;
    logic [DM_W-1:0]   dm;
    logic [SMP_W-1:0]  data;
  } sds_job_t;

  typedef struct packed {
    logic [CNT_W-1:0]  dm_count;
    logic [LAG_W-1:0]  lag;
  } sds_cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP
  } sds_state_t;

  // index of the last DM in use; zero counts as one, above NDM counts as NDM
  function automatic logic [DM_W-1:0] last_dm(input logic [CNT_W-1:0] dm_count);
    logic [DM_W-1:0] r;
    if (dm_count == '0) begin
      r = '0;
    end else if (int'(dm_count) > NDM) begin
      r = DM_W'(NDM - 1);
    end else begin
      r = DM_W'(dm_count - 1'b1);
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] clip(input logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[ACC_W-1] != v[ACC_W-2]) begin
      r = v[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sds_ram.sv
// ----------------------------------------------------------------------------
// sds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front
// Input side: takes items, drops out-of-range ones and tags the rest as
// delay load, plain sample or frame-ending sample for the back end.
// ----------------------------------------------------------------------------
module sds_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [sds_pkg::CH_W-1:0]          channel,
  input  logic [sds_pkg::DM_W-1:0]          dm_index,
  input  logic [sds_pkg::DLY_W-1:0]         delay,
  input  logic signed [sds_pkg::SMP_W-1:0]  sample,
  input  logic                              q_full,
  input  logic                              clearing,
  output logic                              push,
  output sds_pkg::sds_job_t                 job
);

  logic accept;
  logic keep;

  assign in_stall = q_full | clearing;
  assign accept   = in_valid & ~in_stall;
  assign push     = accept & keep;

  always_comb begin
    job.chan = channel;
    job.dm   = dm_index;
    if (opcode == sds_pkg::OP_LOAD) begin
      job.kind = sds_pkg::JOB_LOAD;
      job.data = sds_pkg::SMP_W'(delay);
      keep     = (int'(channel) < sds_pkg::NCHAN) && (int'(dm_index) < sds_pkg::NDM);
    end else begin
      job.kind = (channel == sds_pkg::CH_W'(sds_pkg::NCHAN - 1)) ? sds_pkg::JOB_FRAME
                                                                  : sds_pkg::JOB_SAMPLE;
      job.data = sample;
      keep     = int'(channel) < sds_pkg::NCHAN;
    end
  end

endmodule

// File: rtl/core/sds_queue.sv
// ----------------------------------------------------------------------------
// sds_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module sds_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sds_pkg::sds_job_t  push_job,
  input  logic               pop,
  output sds_pkg::sds_job_t  head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sds_pkg::sds_job_t  slots [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// File: rtl/core/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back
// Back end: clears the memories after reset, writes loads and samples, and on a
// frame-ending sample sweeps the delay table and history, one read a cycle while
// the output hold has room, summing per subband and total for each DM into a five-entry output hold.
// ----------------------------------------------------------------------------
module sds_back (
  input  logic                              clk,
  input  logic                              rst,
  input  sds_pkg::sds_cfg_t                 cfg,
  input  logic                              empty,
  input  sds_pkg::sds_job_t                 head,
  output logic                              pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sds_pkg::DM_W-1:0]          out_dm,
  output logic [sds_pkg::BAND_W-1:0]        out_band,
  output logic signed [sds_pkg::SUM_W-1:0]  sum,
  output logic                              last
);

  localparam int CH_W    = sds_pkg::CH_W;
  localparam int DM_W    = sds_pkg::DM_W;
  localparam int POS_W   = sds_pkg::POS_W;
  localparam int ACC_W   = sds_pkg::ACC_W;
  localparam int SUM_W   = sds_pkg::SUM_W;
  localparam int SMP_W   = sds_pkg::SMP_W;
  localparam int DLY_W   = sds_pkg::DLY_W;
  localparam int HADDR_W = sds_pkg::HADDR_W;
  localparam int DADDR_W = sds_pkg::DADDR_W;
  localparam int NSUB    = sds_pkg::NSUB;

  sds_pkg::sds_state_t state, state_next;

  logic [HADDR_W-1:0]      clr_addr;
  logic [POS_W-1:0]        write_pos;
  logic [POS_W-1:0]        base;

  logic                    issuing;
  logic [DM_W-1:0]         iss_k;
  logic [CH_W-1:0]         iss_c;
  logic                    b_valid;
  logic [DM_W-1:0]         b_k;
  logic [CH_W-1:0]         b_c;
  logic                    c_valid;
  logic [DM_W-1:0]         c_k;
  logic [CH_W-1:0]         c_c;

  logic signed [ACC_W-1:0] acc      [0:NSUB];
  logic signed [ACC_W-1:0] acc_next [0:NSUB];
  logic signed [SUM_W-1:0] hold_sum [0:NSUB];
  logic [DM_W-1:0]         hold_dm;
  logic [sds_pkg::BAND_W-1:0] hold_band;
  logic                    hold_last;
  logic                    hold_valid;
  logic                    hold_free;
  logic                    out_accept;

  logic [DM_W-1:0]         dm_last;
  logic                    adv;
  logic                    c_chan_last;
  logic                    sweep_done;
  logic [sds_pkg::SUB_W-1:0] sb;

  logic                    h_we;
  logic [HADDR_W-1:0]      h_waddr;
  logic [SMP_W-1:0]        h_wdata;
  logic                    h_re;
  logic [HADDR_W-1:0]      h_raddr;
  logic [SMP_W-1:0]        h_rdata;
  logic                    d_we;
  logic [DADDR_W-1:0]      d_waddr;
  logic [DLY_W-1:0]        d_wdata;
  logic                    d_re;
  logic [DADDR_W-1:0]      d_raddr;
  logic [DLY_W-1:0]        d_rdata;
  logic [POS_W-1:0]        rd_pos;

  function automatic logic c_chan_last_iss(input logic [CH_W-1:0] c);
    return c == CH_W'(sds_pkg::NCHAN - 1);
  endfunction

  assign dm_last     = sds_pkg::last_dm(cfg.dm_count);
  assign c_chan_last = (c_c == CH_W'(sds_pkg::NCHAN - 1));
  assign out_accept  = hold_valid & ~out_stall;
  assign hold_free   = ~hold_valid | (out_accept & (hold_band == sds_pkg::BAND_W'(NSUB)));
  // the sweep pipeline freezes when a finished DM cannot move into the hold
  assign adv         = ~(c_valid & c_chan_last & ~hold_free);
  assign sweep_done  = ~issuing & ~b_valid & ~c_valid;

  // ring offsets wrap at the history depth
  assign rd_pos  = base + POS_W'(d_rdata);
  assign d_re    = adv & issuing;
  assign d_raddr = {iss_k, iss_c};
  assign h_re    = adv & b_valid;
  assign h_raddr = {b_c, rd_pos};
  assign sb      = sds_pkg::SUB_W'(c_c / sds_pkg::CH_PER_SUB);

  sds_ram #(
    .WIDTH (SMP_W),
    .DEPTH (sds_pkg::NCHAN * sds_pkg::HIST)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sds_ram #(
    .WIDTH (DLY_W),
    .DEPTH (sds_pkg::NDM * sds_pkg::NCHAN)
  ) u_delay_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      sds_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = sds_pkg::ST_IDLE;
        end
      end
      sds_pkg::ST_IDLE: begin
        if (!empty && head.kind == sds_pkg::JOB_FRAME) begin
          state_next = sds_pkg::ST_SWEEP;
        end
      end
      sds_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_next = sds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sds_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clearing = 1'b0;
    pop      = 1'b0;
    h_we     = 1'b0;
    h_waddr  = {head.chan, write_pos};
    h_wdata  = head.data;
    d_we     = 1'b0;
    d_waddr  = {head.dm, head.chan};
    d_wdata  = head.data[DLY_W-1:0];
    case (state)
      sds_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        h_we     = 1'b1;
        h_waddr  = clr_addr;
        h_wdata  = '0;
        d_we     = clr_addr < HADDR_W'(sds_pkg::NDM * sds_pkg::NCHAN);
        d_waddr  = clr_addr[DADDR_W-1:0];
        d_wdata  = '0;
      end
      sds_pkg::ST_IDLE: begin
        pop = ~empty;
        if (!empty) begin
          case (head.kind)
            sds_pkg::JOB_LOAD: begin
              d_we = 1'b1;
            end
            sds_pkg::JOB_SAMPLE, sds_pkg::JOB_FRAME: begin
              h_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sds_pkg::ST_SWEEP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int b = 0; b < NSUB; b++) begin
      acc_next[b] = acc[b] + ((int'(sb) == b) ? ACC_W'($signed(h_rdata)) : '0);
    end
    acc_next[NSUB] = acc[NSUB] + ACC_W'($signed(h_rdata));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sds_pkg::ST_CLEAR;
      clr_addr   <= '0;
      write_pos  <= '0;
      issuing    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      hold_valid <= 1'b0;
      hold_band  <= '0;
    end else begin
      state <= state_next;
      if (state == sds_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop && head.kind == sds_pkg::JOB_FRAME) begin
        write_pos <= write_pos + 1'b1;
        issuing   <= 1'b1;
      end else if (adv && issuing && c_chan_last_iss(iss_c) && iss_k == dm_last) begin
        issuing <= 1'b0;
      end
      if (adv) begin
        b_valid <= issuing;
        c_valid <= b_valid;
      end
      if (adv && c_valid && c_chan_last) begin
        hold_valid <= 1'b1;
        hold_band  <= '0;
      end else if (out_accept) begin
        if (hold_band == sds_pkg::BAND_W'(NSUB)) begin
          hold_valid <= 1'b0;
        end else begin
          hold_band <= hold_band + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == sds_pkg::JOB_FRAME) begin
      base  <= write_pos - cfg.lag[POS_W-1:0];
      iss_k <= '0;
      iss_c <= '0;
      for (int b = 0; b <= NSUB; b++) begin
        acc[b] <= '0;
      end
    end else if (adv) begin
      if (issuing) begin
        iss_c <= iss_c + 1'b1;
        if (c_chan_last_iss(iss_c)) begin
          iss_k <= iss_k + 1'b1;
        end
      end
      b_k <= iss_k;
      b_c <= iss_c;
      c_k <= b_k;
      c_c <= b_c;
      if (c_valid) begin
        if (c_chan_last) begin
          for (int b = 0; b <= NSUB; b++) begin
            hold_sum[b] <= sds_pkg::clip(acc_next[b]);
            acc[b]      <= '0;
          end
          hold_dm   <= c_k;
          hold_last <= (c_k == dm_last);
        end else begin
          for (int b = 0; b <= NSUB; b++) begin
            acc[b] <= acc_next[b];
          end
        end
      end
    end
  end

  assign out_valid = hold_valid;
  assign out_dm    = hold_dm;
  assign out_band  = hold_band;
  assign sum       = hold_sum[hold_band];
  assign last      = hold_last & (hold_band == sds_pkg::BAND_W'(NSUB));

endmodule

// File: rtl/core/subband_dedispersion_sum_unit.sv
// A load or plain sample passes the queue and is written when the idle back end pops it;
// the last channel of a time step is written too and starts a sweep that reads the delay
// table, then history, one read a cycle while the output hold has room, and shows each DM's
// sums once that DM is summed; the queue keeps taking items during the sweep until it fills.
// Reset: a clearing pass zeroes history and delay table; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
// subband_dedispersion_sum_unit
// Streaming shift-and-sum dedispersion: a classifying front end and a queue
// feed a back end that owns the history ring, the delay table and the sums.
// ----------------------------------------------------------------------------
module subband_dedispersion_sum_unit #(
  parameter int QDEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic [sds_pkg::CH_W-1:0]              channel,
  input  logic [sds_pkg::DM_W-1:0]              dm_index,
  input  logic [sds_pkg::DLY_W-1:0]             delay,
  input  logic signed [sds_pkg::SMP_W-1:0]      sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sds_pkg::DM_W-1:0]              out_dm,
  output logic [sds_pkg::BAND_W-1:0]            out_band,
  output logic signed [sds_pkg::SUM_W-1:0]      sum,
  output logic                                  last
);

  sds_pkg::sds_cfg_t cfg;
  sds_pkg::sds_job_t push_job;
  sds_pkg::sds_job_t head;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dm_count <= sds_pkg::DM_COUNT_RST;
      cfg.lag      <= sds_pkg::LAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sds_pkg::REG_DM_COUNT: cfg.dm_count <= cfg_data[sds_pkg::CNT_W-1:0];
        sds_pkg::REG_LAG:      cfg.lag      <= cfg_data[sds_pkg::LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sds_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .channel  (channel),
    .dm_index (dm_index),
    .delay    (delay),
    .sample   (sample),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .job      (push_job)
  );

  sds_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_dm    (out_dm),
    .out_band  (out_band),
    .sum       (sum),
    .last      (last)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("item taken during memory clear");

  a_clear_no_output: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result shown during memory clear");

  a_last_on_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_band == sds_pkg::BAND_W'(sds_pkg::NSUB)))
    else $error("last flag not on a total");

endmodule
